@@ rtl/core/sct_pkg.sv @@
// Shared types and constants for the sleep countdown table.
package sct_pkg;

    // Fixed field widths of the stream payloads
    localparam int ID_W     = 8;
    localparam int TICKS_W  = 32;
    localparam int S_DATA_W = 40;  // thread id + tick count, whole bytes
    localparam int M_DATA_W = 8;   // woken id

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_SLEEP = 1'b1
    } cmd_op_t;

    typedef enum logic {
        RES_WAKE   = 1'b0,
        RES_REFUSE = 1'b1
    } res_kind_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [ID_W-1:0]  thread;
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } back_state_t;

endpackage

@@ rtl/core/sct_front.sv @@
// Input side: takes stream transfers, drops no-op sleeps, saturates the tick count.
module sct_front #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sct_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] thread_id, [39:8] sleep_ticks
    input  logic                          s_tuser,   // operation
    input  logic                          q_full,
    output logic                          push,
    output sct_pkg::cmd_t                 push_cmd,
    output logic [COUNT_WIDTH-1:0]        push_ticks
);
    import sct_pkg::*;

    logic [TICKS_W-1:0]     ticks_in;
    logic [COUNT_WIDTH-1:0] ticks_sat;
    logic                   drop;

    assign ticks_in = s_tdata[ID_W +: TICKS_W];

    // Clamp the tick count to what the counters can hold
    generate
        if (COUNT_WIDTH >= TICKS_W) begin : g_wide
            assign ticks_sat = COUNT_WIDTH'(ticks_in);
        end else begin : g_narrow
            assign ticks_sat = (|ticks_in[TICKS_W-1:COUNT_WIDTH]) ? '1
                                                                   : ticks_in[COUNT_WIDTH-1:0];
        end
    endgenerate

    // A sleep of zero ticks is taken and discarded
    assign drop = (cmd_op_t'(s_tuser) == CMD_SLEEP) && (ticks_in == '0);

    assign s_tready        = !q_full;
    assign push            = s_tvalid && !q_full && !drop;
    assign push_cmd.op     = cmd_op_t'(s_tuser);
    assign push_cmd.thread = s_tdata[ID_W-1:0];
    assign push_ticks      = ticks_sat;

endmodule

@@ rtl/core/sct_queue.sv @@
// Short command queue decoupling the front from the table engine.
module sct_queue #(
    parameter int W = 41
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] pop_data
);
    import sct_pkg::*;

    logic [W-1:0]      store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/sct_back.sv @@
// Table engine: head insert for sleeps, rotating countdown walk for ticks, result register.
module sct_back #(
    parameter int MAX_SLEEPERS = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  sct_pkg::cmd_t                 cmd,
    input  logic [COUNT_WIDTH-1:0]        cmd_ticks,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sct_pkg::M_DATA_W-1:0]  m_tdata,   // [7:0] woken_id
    output logic                          m_tuser,   // kind
    output logic                          m_tlast    // last
);
    import sct_pkg::*;

    localparam int LW = $clog2(MAX_SLEEPERS + 1);

    // Table: slot 0 is the head, slots below len_reg are valid
    logic [ID_W-1:0]        thread_reg [MAX_SLEEPERS];
    logic [COUNT_WIDTH-1:0] remain_reg [MAX_SLEEPERS];
    logic [ID_W-1:0]        thread_next [MAX_SLEEPERS];
    logic [COUNT_WIDTH-1:0] remain_next [MAX_SLEEPERS];
    logic [LW-1:0]          len_reg, len_next, len_m1;

    back_state_t            state_reg, state_next;
    logic [LW-1:0]          rem_reg, rem_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]        pend_id_reg, pend_id_next;

    logic                   out_valid_reg;
    res_kind_t              out_kind_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic                   out_last_reg;

    logic                   can_push, push, push_last;
    res_kind_t              push_kind;
    logic [ID_W-1:0]        push_id;
    logic                   do_insert, do_shift, keep;
    logic                   head_wake;
    logic [COUNT_WIDTH-1:0] head_dec;

    assign can_push  = !out_valid_reg || m_tready;
    assign head_wake = (remain_reg[0][COUNT_WIDTH-1:1] == '0);
    assign head_dec  = remain_reg[0] - 1'b1;
    assign len_m1    = len_reg - 1'b1;

    // Sequencer: one command at a time, a tick visits each entry once
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        rem_next        = rem_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pop             = 1'b0;
        do_insert       = 1'b0;
        do_shift        = 1'b0;
        keep            = 1'b0;
        push            = 1'b0;
        push_kind       = RES_WAKE;
        push_id         = pend_id_reg;
        push_last       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == CMD_SLEEP)
                    begin
                        if (len_reg == LW'(MAX_SLEEPERS))
                        begin
                            // full: refuse once the result register is free
                            if (can_push)
                            begin
                                push      = 1'b1;
                                push_kind = RES_REFUSE;
                                push_id   = cmd.thread;
                                push_last = 1'b1;
                                pop       = 1'b1;
                            end
                        end
                        else
                        begin
                            do_insert = 1'b1;
                            len_next  = len_reg + 1'b1;
                            pop       = 1'b1;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        rem_next   = len_reg;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (rem_reg != '0)
                begin
                    if (!head_wake)
                    begin
                        // survivor rotates to the tail, one tick less
                        do_shift = 1'b1;
                        keep     = 1'b1;
                        rem_next = rem_reg - 1'b1;
                    end
                    else if (!pend_valid_reg || can_push)
                    begin
                        // expired head leaves; the previous wake goes out unmarked
                        do_shift        = 1'b1;
                        rem_next        = rem_reg - 1'b1;
                        len_next        = len_reg - 1'b1;
                        pend_valid_next = 1'b1;
                        pend_id_next    = thread_reg[0];
                        push            = pend_valid_reg;
                    end
                end
                else
                begin
                    // walk done: the held wake is the final one
                    if (!pend_valid_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (can_push)
                    begin
                        push            = 1'b1;
                        push_last       = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Per-slot next values: insert shifts tailwards, walk shifts headwards
    genvar gi;
    generate
        for (gi = 0; gi < MAX_SLEEPERS; gi++) begin : g_slot
            logic [ID_W-1:0]        lo_thread, up_thread;
            logic [COUNT_WIDTH-1:0] lo_remain, up_remain;

            if (gi == 0) begin : g_lo_head
                assign lo_thread = cmd.thread;
                assign lo_remain = cmd_ticks;
            end else begin : g_lo_body
                assign lo_thread = thread_reg[gi-1];
                assign lo_remain = remain_reg[gi-1];
            end

            if (gi == MAX_SLEEPERS - 1) begin : g_up_tail
                assign up_thread = thread_reg[gi];
                assign up_remain = remain_reg[gi];
            end else begin : g_up_body
                assign up_thread = thread_reg[gi+1];
                assign up_remain = remain_reg[gi+1];
            end

            always_comb
            begin
                thread_next[gi] = thread_reg[gi];
                remain_next[gi] = remain_reg[gi];
                if (do_insert)
                begin
                    thread_next[gi] = lo_thread;
                    remain_next[gi] = lo_remain;
                end
                else if (do_shift)
                begin
                    if (keep && (len_m1 == LW'(gi)))
                    begin
                        thread_next[gi] = thread_reg[0];
                        remain_next[gi] = head_dec;
                    end
                    else
                    begin
                        thread_next[gi] = up_thread;
                        remain_next[gi] = up_remain;
                    end
                end
            end
        end
    endgenerate

    // Table payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_SLEEPERS; i++)
        begin
            thread_reg[i] <= thread_next[i];
            remain_reg[i] <= remain_next[i];
        end
        pend_id_reg <= pend_id_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_kind_reg <= push_kind;
            out_id_reg   <= push_id;
            out_last_reg <= push_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/core/sleep_countdown_table.sv @@
// Sleep countdown table: top level joining front, command queue and table engine.
//
// Input stream: s_tuser selects the operation (0 = timer tick, 1 = sleep),
// s_tdata carries the thread id and the tick count. A sleep of zero ticks is
// taken and discarded. A sleep puts the thread at the head of the table; if
// the table is full one refusal result (m_tuser = 1, m_tlast = 1) comes out.
// A tick counts every entry down and gives one wake result (m_tuser = 0) per
// expired entry, head to tail, m_tlast on the final one; none if none expire.
// With the engine idle, a sleep is registered in the command queue and then
// in the table. A tick walks the table one entry per cycle, pausing on an
// expired entry while the result register is stalled; each wake is held until
// the next expired entry is found or the walk ends, so the final one can carry m_tlast.
// Throughput: one command at a time in the table engine; a two-entry queue
// lets the input keep taking transfers while a walk is under way.
// Reset empties the table and the queue at once. When the receiver stalls,
// the single result register holds its transfer and the walk pauses on the
// next expired entry; input transfers stop once the queue is full.
module sleep_countdown_table #(
    parameter int MAX_SLEEPERS = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sct_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] thread_id, [39:8] sleep_ticks
    input  logic                          s_tuser,   // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sct_pkg::M_DATA_W-1:0]  m_tdata,   // [7:0] woken_id
    output logic                          m_tuser,   // kind
    output logic                          m_tlast    // last
);
    import sct_pkg::*;

    localparam int QW = COUNT_WIDTH + $bits(cmd_t);

    logic                   q_full, q_push, q_pop, q_not_empty;
    cmd_t                   push_cmd, pop_cmd;
    logic [COUNT_WIDTH-1:0] push_ticks, pop_ticks;
    logic [QW-1:0]          q_wdata, q_rdata;

    assign q_wdata   = {push_ticks, push_cmd};
    assign pop_cmd   = cmd_t'(q_rdata[$bits(cmd_t)-1:0]);
    assign pop_ticks = q_rdata[QW-1:$bits(cmd_t)];

    sct_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ticks (push_ticks)
    );

    sct_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_rdata)
    );

    sct_back #(
        .MAX_SLEEPERS (MAX_SLEEPERS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (pop_cmd),
        .cmd_ticks (pop_ticks),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the sleep countdown table: prediction, stimulus and checks.
`timescale 1ns / 1ps

module testbench;

    import sct_pkg::*;

    localparam int SLOTS       = 16;
    localparam int RESET_CYC   = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 180;

    // One result transfer as the table should emit it
    typedef struct {
        res_kind_t        kind;
        logic [ID_W-1:0]  id;
        logic             last;
    } wake_res_t;

    // Scoreboard: mirrors the sleeper table and holds the results still owed
    class wake_scoreboard;
        logic [ID_W-1:0]    table_thread [SLOTS];
        logic [TICKS_W-1:0] table_left   [SLOTS];
        int                 occupancy;
        wake_res_t          wakes_due [$];
        int                 errors;

        function new();
            occupancy = 0;
            errors    = 0;
        endfunction

        function bit is_full();
            return occupancy >= SLOTS;
        endfunction

        function int pending();
            return wakes_due.size();
        endfunction

        // Accepted command: update the table copy and queue what it causes
        function void note_command(cmd_op_t op, logic [ID_W-1:0] id,
                                   logic [TICKS_W-1:0] ticks);
            wake_res_t r;
            int        keep;
            int        woke;
            int        seen;
            keep = 0;
            woke = 0;
            seen = 0;
            if (op == CMD_SLEEP) begin
                if (ticks == '0)
                    return;
                if (is_full()) begin
                    r.kind = RES_REFUSE;
                    r.id   = id;
                    r.last = 1'b1;
                    wakes_due.push_back(r);
                    return;
                end
                // new sleeper goes to the head, the rest move one slot down
                for (int i = occupancy; i > 0; i--) begin
                    table_thread[i] = table_thread[i-1];
                    table_left[i]   = table_left[i-1];
                end
                table_thread[0] = id;
                table_left[0]   = ticks;
                occupancy++;
                return;
            end
            // tick: count how many expire so the final one can carry last
            for (int i = 0; i < occupancy; i++)
                if (table_left[i] <= 1)
                    woke++;
            for (int i = 0; i < occupancy; i++) begin
                if (table_left[i] <= 1) begin
                    seen++;
                    r.kind = RES_WAKE;
                    r.id   = table_thread[i];
                    r.last = (seen == woke);
                    wakes_due.push_back(r);
                end
                else begin
                    table_thread[keep] = table_thread[i];
                    table_left[keep]   = table_left[i] - 1;
                    keep++;
                end
            end
            occupancy = keep;
        endfunction

        // Result transfer: compare against the oldest outstanding result
        function void check_result(logic kind, logic [M_DATA_W-1:0] id, logic last);
            wake_res_t exp_r;
            if (wakes_due.size() == 0) begin
                $error("unexpected result: kind %0d id 0x%02h last %0d", kind, id, last);
                errors++;
                return;
            end
            exp_r = wakes_due.pop_front();
            if (kind !== exp_r.kind) begin
                $error("kind: expected %0d, got %0d", exp_r.kind, kind);
                errors++;
            end
            if (id !== exp_r.id) begin
                $error("woken_id: expected 0x%02h, got 0x%02h", exp_r.id, id);
                errors++;
            end
            if (last !== exp_r.last) begin
                $error("last: expected %0d, got %0d", exp_r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    wake_scoreboard sb = new();

    int burst_left = 0;
    bit hold_req   = 1'b0;
    int idle_cycles = 0;

    sleep_countdown_table #(
        .MAX_SLEEPERS (SLOTS),
        .COUNT_WIDTH  (TICKS_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // Offer one command, in bursts with random gaps, and wait for its transfer
    task automatic send_command(input cmd_op_t op, input logic [ID_W-1:0] id,
                                input logic [TICKS_W-1:0] ticks);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {ticks, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_command(op, id, ticks);
        burst_left--;
    endtask

    // Sleep request; a full table gets a wide random count to exercise every bit
    task automatic send_sleep(input int hi_ticks);
        logic [TICKS_W-1:0] ticks;
        if (sb.is_full())
            ticks = $urandom;
        else
            ticks = $urandom_range(1, hi_ticks);
        send_command(CMD_SLEEP, ID_W'($urandom_range(0, 255)), ticks);
    endtask

    // Stimulus
    initial begin : stimulus
        int issued;
        int roll;
        bit first_fill;
        issued     = 0;
        first_fill = 1'b1;

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty tick, zero-count sleep, a full table and its refusal
        send_command(CMD_TICK, 8'h00, '0);
        send_command(CMD_SLEEP, 8'h00, '0);
        for (int i = 0; i < SLOTS; i++) begin
            if (i == 0)
                send_command(CMD_SLEEP, 8'h00, 32'd1);
            else if (i == SLOTS - 1)
                send_command(CMD_SLEEP, 8'hFF, 32'd1);
            else if (i == 7)
                send_command(CMD_SLEEP, 8'h16, 32'd1);  // same id as slot 6
            else
                send_command(CMD_SLEEP, ID_W'(8'h10 + i), 32'd1);
        end
        send_command(CMD_SLEEP, 8'h81, 32'h7FFF_FFFF);
        // every sleeper expires at once: a full run of wakes
        send_command(CMD_TICK, 8'h00, '0);
        // largest count stays resident for the rest of the run
        send_command(CMD_SLEEP, 8'hFF, 32'hFFFF_FFFF);
        send_command(CMD_SLEEP, 8'h3C, 32'd2);
        send_command(CMD_TICK, 8'h00, '0);  // nobody wakes
        send_command(CMD_TICK, 8'h00, '0);

        // random: fill episodes and mixed runs
        while (issued < RANDOM_ITEMS) begin
            if (first_fill || $urandom_range(0, 9) < 3) begin
                while (!sb.is_full()) begin
                    send_sleep(5);
                    issued++;
                end
                repeat ($urandom_range(1, 2)) begin
                    send_sleep(5);
                    issued++;
                end
                // on the first fill the receiver holds off while ticks keep coming
                if (first_fill) begin
                    hold_req   = 1'b1;
                    first_fill = 1'b0;
                end
                repeat (6) begin
                    send_command(CMD_TICK, ID_W'($urandom_range(0, 255)), $urandom);
                    issued++;
                end
            end
            else begin
                repeat (12) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 45) begin
                        send_command(CMD_TICK, ID_W'($urandom_range(0, 255)), $urandom);
                        issued++;
                    end
                    else if (roll < 90) begin
                        send_sleep(($urandom_range(0, 7) == 0) ? 12 : 4);
                        issued++;
                    end
                    else begin
                        send_command(CMD_SLEEP, ID_W'($urandom_range(0, 255)), '0);
                    end
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain, then allow a full walk for any stray result
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        if (sb.errors == 0)
            $display("[sleep_countdown_table] OK");
        else
            $display("[sleep_countdown_table] ERROR");
        $finish;
    end

    // Receiver: stall pattern changes per stretch, plus one long hold-off
    initial begin : ready_pattern
        int span_left;
        int stall_pct;
        int hold_left;
        span_left = 0;
        stall_pct = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                if (span_left == 0) begin
                    span_left = $urandom_range(20, 120);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                span_left--;
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    // Watchdog: too long without a transfer on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[sleep_countdown_table] ERROR");
                $finish;
            end
        end
    end

endmodule
